>>> rtl/core/wildcard_byte_pattern_search_macros.svh
// assertion macros for the wildcard byte pattern search block
// expects clk_i and rst_ni in the scope of use
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH

// same-cycle implication
`define WBPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern search block
// no dependencies
package wbps_pkg;

  localparam int MAX_PATTERN  = 16;
  localparam int ADDRESS_BITS = 32;
  localparam int REG_BYTES    = 16;

  // number of compare cells actually usable
  localparam int NUM_CELLS = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
  localparam int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int LEN_W     = 5;
  localparam int ADDR_W    = 32;
  localparam int CFG_W     = 64;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  typedef enum logic [2:0] {
    CFG_PAT_LO = 3'd0,
    CFG_PAT_HI = 3'd1,
    CFG_CARE   = 3'd2,
    CFG_LEN    = 3'd3,
    CFG_BASE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic advance;
    logic flush;
  } cell_ctl_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } result_t;

endpackage

>>> rtl/core/wbps_cell.sv
// one window cell of the byte shift chain with its masked compare
// depends on wbps_pkg
module wbps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wbps_pkg::cell_ctl_t ctl_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          pat_i,
  input  logic                care_i,
  output logic                hit_o,
  output logic [7:0]          data_o
);

  logic [7:0] data_q;

  // window byte at this slot agrees with its lined-up pattern byte, or is not cared about
  assign hit_o  = ~care_i | (data_i == pat_i);
  assign data_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (ctl_i.advance) begin
      data_q <= ctl_i.flush ? 8'h00 : data_i;
    end
  end

endmodule

>>> rtl/core/wbps_obuf.sv
// output register with one skid stage
// depends on wbps_pkg
module wbps_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  wbps_pkg::result_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wbps_pkg::result_t out_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  wbps_pkg::result_t out_q;
  wbps_pkg::result_t skid_q;
  logic              out_fire;

  assign out_fire    = out_valid_q & ~out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid_i) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid_i) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res_i;
      end else begin
        out_q <= res_i;
      end
    end
  end

endmodule

>>> rtl/core/wildcard_byte_pattern_search.sv
// Takes one byte per clock cycle unless the input stalls, with no gaps
// between regions. Each byte enters a row of window cells; cell k holds the
// byte seen k bytes earlier, hands it to cell k+1 on every accepted byte but
// the last of a region and compares it with the pattern byte that lines up
// with it, so a full match is known in the cycle its last byte arrives. The
// result (found with base plus start offset, or not-found at the end of a
// region) is registered in the output buffer. An output register and a skid
// stage hold up to two results; input stalls only while both are full.
// Configuration must be written while the block is idle.
// Built from wbps_cell and wbps_obuf, with types and constants from wbps_pkg.
module wildcard_byte_pattern_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [wbps_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [wbps_pkg::ADDR_W-1:0]   match_address_o
);

  localparam int N = wbps_pkg::NUM_CELLS;

  logic [63:0]                      pat_lo_q;
  logic [63:0]                      pat_hi_q;
  logic [15:0]                      care_q;
  logic [wbps_pkg::LEN_W-1:0]       len_q;
  logic [wbps_pkg::ADDR_W-1:0]      base_q;
  logic [wbps_pkg::ADDR_W-1:0]      pos_q;
  logic                             reported_q;

  logic [15:0][7:0]                 pat_all;
  logic [wbps_pkg::LEN_W-1:0]       eff_len;
  logic [wbps_pkg::ADDR_W-1:0]      seen;
  logic [wbps_pkg::ADDR_W-1:0]      addr;
  logic [N-1:0]                     hit_vec;
  logic [N:0][7:0]                  win;
  logic                             in_fire;
  logic                             hit;
  logic                             res_valid;
  logic                             full;
  wbps_pkg::cell_ctl_t              ctl;
  wbps_pkg::result_t                res;
  wbps_pkg::result_t                out_res;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '1;
      len_q    <= '0;
      base_q   <= '0;
    end else if (cfg_we_i) begin
      case (wbps_pkg::cfg_idx_e'(cfg_idx_i))
        wbps_pkg::CFG_PAT_LO: pat_lo_q <= cfg_data_i;
        wbps_pkg::CFG_PAT_HI: pat_hi_q <= cfg_data_i;
        wbps_pkg::CFG_CARE:   care_q   <= cfg_data_i[15:0];
        wbps_pkg::CFG_LEN:    len_q    <= cfg_data_i[wbps_pkg::LEN_W-1:0];
        wbps_pkg::CFG_BASE:   base_q   <= cfg_data_i[wbps_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_hi_q, pat_lo_q};
  assign eff_len = (len_q > wbps_pkg::LEN_W'(N)) ? wbps_pkg::LEN_W'(N) : len_q;

  assign in_fire     = in_valid_i & ~full;
  assign in_stall_o  = full;
  assign ctl.advance = in_fire;
  assign ctl.flush   = last_byte_i;

  assign win[0] = data_byte_i;

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [wbps_pkg::IDX_W-1:0] pidx;
    logic                       care_sel;

    // slot k lines up with pattern byte len-1-k
    assign pidx     = wbps_pkg::IDX_W'(eff_len - wbps_pkg::LEN_W'(k + 1));
    assign care_sel = (wbps_pkg::LEN_W'(k) < eff_len) & care_q[pidx];

    wbps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .data_i  (win[k]),
      .pat_i   (pat_all[pidx]),
      .care_i  (care_sel),
      .hit_o   (hit_vec[k]),
      .data_o  (win[k+1])
    );
  end

  // saturating byte count including the current byte
  assign seen = (&pos_q) ? pos_q : pos_q + wbps_pkg::ADDR_W'(1);
  assign addr = (base_q + seen - wbps_pkg::ADDR_W'(eff_len)) & wbps_pkg::ADDR_MASK;

  assign hit       = ~reported_q & (eff_len != '0) &
                     (seen >= wbps_pkg::ADDR_W'(eff_len)) & (&hit_vec);
  assign res_valid = in_fire & (hit | (last_byte_i & ~reported_q));
  assign res.found = hit;
  assign res.addr  = hit ? addr : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      reported_q <= 1'b0;
    end else if (in_fire) begin
      if (last_byte_i) begin
        pos_q      <= '0;
        reported_q <= 1'b0;
      end else begin
        pos_q      <= seen;
        reported_q <= reported_q | hit;
      end
    end
  end

  wbps_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign found_o         = out_res.found;
  assign match_address_o = out_res.addr;

`include "wildcard_byte_pattern_search_macros.svh"

  `WBPS_ASSERT_NOW(a_skid_implies_out, full, out_valid_o, "skid stage full with empty output")
  `WBPS_ASSERT_NOW(a_notfound_zero, out_valid_o && !found_o, match_address_o == '0,
                   "nonzero not-found address")
  `WBPS_ASSERT_NEXT(a_region_clear, in_fire && last_byte_i, pos_q == '0 && !reported_q,
                    "region state kept")
  `WBPS_ASSERT_NEXT(a_hit_gives_result, in_fire && hit, out_valid_o, "match result lost")

endmodule

>>> dv/wbps_scoreboard_pkg.sv
// scoreboard for the wildcard byte pattern search testbench
// keeps its own copy of registers and scan state and checks each result transaction
// depends on wbps_pkg
package wbps_scoreboard_pkg;
  import wbps_pkg::*;

  class scan_scoreboard;
    logic [CFG_W-1:0]  pat_lo;
    logic [CFG_W-1:0]  pat_hi;
    logic [15:0]       care;
    logic [LEN_W-1:0]  plen;
    logic [ADDR_W-1:0] base;
    logic [7:0]        window [MAX_PATTERN];
    logic [31:0]       offset;
    bit                matched;
    result_t           expected_q [$];
    int                errors;
    int                n_found;
    int                n_missed;
    int                n_bytes;

    function new();
      pat_lo   = '0;
      pat_hi   = '0;
      care     = 16'hffff;
      plen     = '0;
      base     = '0;
      errors   = 0;
      n_found  = 0;
      n_missed = 0;
      n_bytes  = 0;
      clear_region();
    endfunction

    function void clear_region();
      foreach (window[i]) window[i] = 8'h00;
      offset  = '0;
      matched = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_PAT_LO: pat_lo = d;
        CFG_PAT_HI: pat_hi = d;
        CFG_CARE:   care = d[15:0];
        CFG_LEN:    plen = d[LEN_W-1:0];
        CFG_BASE:   base = d[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    function int eff_len();
      return (int'(plen) > NUM_CELLS) ? NUM_CELLS : int'(plen);
    endfunction

    function logic [7:0] pat_byte(int k);
      logic [2*CFG_W-1:0] p;
      p = {pat_hi, pat_lo};
      return p[8*k +: 8];
    endfunction

    function void note_input(logic [7:0] b, logic is_last);
      int          len;
      logic [31:0] seen;
      bit          hit;
      result_t     r;
      len = eff_len();
      for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      seen = (offset == '1) ? offset : offset + 32'd1;
      n_bytes++;
      if (!matched && len > 0 && seen >= 32'(len)) begin
        hit = 1'b1;
        for (int k = 0; k < len; k++)
          if (care[k] && window[len-1-k] !== pat_byte(k)) hit = 1'b0;
        if (hit) begin
          r.found = 1'b1;
          r.addr  = ADDR_W'(base + (seen - 32'(len))) & ADDR_MASK;
          expected_q.push_back(r);
          matched = 1'b1;
        end
      end
      offset = seen;
      if (is_last) begin
        if (!matched) begin
          r.found = 1'b0;
          r.addr  = '0;
          expected_q.push_back(r);
        end
        clear_region();
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic found, logic [ADDR_W-1:0] addr);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: found %0b addr %h", found, addr));
      end else begin
        want = expected_q.pop_front();
        if (found !== want.found)
          report($sformatf("found %0b, want %0b", found, want.found));
        if (addr !== want.addr)
          report($sformatf("match_address %h, want %h", addr, want.addr));
        if (want.found) n_found++;
        else n_missed++;
      end
    endtask
  endclass

endpackage

>>> dv/tb_wildcard_byte_pattern_search.sv
// top-level testbench for wildcard_byte_pattern_search
// drives directed and random byte regions under several register settings and idle mixes
// depends on wbps_pkg, wbps_scoreboard_pkg and the block rtl
module tb_wildcard_byte_pattern_search;
  import wbps_pkg::*;
  import wbps_scoreboard_pkg::*;

  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         RANDOM_BYTES   = 1000;
  localparam logic [2:0] CFG_IDX_TOP    = 3'd7;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [2:0]        cfg_idx_i   = CFG_PAT_LO;
  logic [CFG_W-1:0]  cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i = 8'h00;
  logic              last_byte_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              found_o;
  logic [ADDR_W-1:0] match_address_o;

  scan_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int settings_used  = 0;

  wildcard_byte_pattern_search DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_reg(cfg_idx_i, cfg_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(found_o, match_address_o);
      if (in_valid_i && !in_stall_o) sb.note_input(data_byte_i, last_byte_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_wildcard_byte_pattern_search failed");
        $finish;
      end
    end
  end

  function automatic logic [CFG_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
  endtask

  task automatic program_block(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                               logic [CFG_W-1:0] care, logic [CFG_W-1:0] len,
                               logic [CFG_W-1:0] base, bit junk);
    write_reg(CFG_PAT_LO, lo);
    write_reg(CFG_PAT_HI, hi);
    write_reg(CFG_CARE, care);
    write_reg(CFG_LEN, len);
    write_reg(CFG_BASE, base);
    if (junk)
      for (int i = int'(CFG_BASE) + 1; i <= int'(CFG_IDX_TOP); i++) write_reg(3'(i), rand64());
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  task automatic send_byte(logic [7:0] b, logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly regions holding the pattern, some cut off at the end or with a bad byte
  task automatic send_scan_region();
    logic [7:0] bytes [$];
    int len, span, at, kind, k;
    len  = sb.eff_len();
    kind = $urandom_range(9);
    span = $urandom_range(1, 24);
    at   = 0;
    if (len > 0 && kind < 8) begin
      span = len + $urandom_range(0, 20);
      at   = $urandom_range(0, span - len);
      if (kind == 7) at = span - len + 1;
    end
    for (int i = 0; i < span; i++) bytes.push_back(8'($urandom));
    if (len > 0 && kind < 8) begin
      for (int j = 0; j < len; j++)
        if (at + j < span && sb.care[j]) bytes[at+j] = sb.pat_byte(j);
      if (kind == 6) begin
        k = $urandom_range(0, len - 1);
        bytes[at+k] = bytes[at+k] ^ (8'h01 << $urandom_range(7));
      end
    end
    foreach (bytes[i]) send_byte(bytes[i], i == span - 1);
  endtask

  task automatic random_config();
    logic [CFG_W-1:0] care, len, base;
    care = rand64();
    case ($urandom_range(3))
      0: care[15:0] = 16'hffff;
      1: care[15:0] = 16'h0000;
      default: ;
    endcase
    len = rand64();
    case ($urandom_range(5))
      0: len[4:0] = 5'd0;
      1: len[4:0] = 5'd1;
      2: len[4:0] = 5'd16;
      3: len[4:0] = 5'($urandom_range(17, 31));
      default: len[4:0] = 5'($urandom_range(2, 15));
    endcase
    base = rand64();
    case ($urandom_range(3))
      0: base[31:0] = '0;
      1: base[31:0] = '1;
      default: ;
    endcase
    program_block(rand64(), rand64(), care, len, base, bit'($urandom_range(1)));
  endtask

  initial begin
    int start_bytes;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers give zero length, so nothing matches
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    wait_idle();

    // over-long length clamps to sixteen, match on the final byte, address equals the base
    program_block(64'h0123_4567_89ab_cd00, 64'hff10_3254_7698_badc,
                  64'ha5a5_0000_1234_ffff, 64'hffff_ffff_ffff_ffff,
                  64'h5a5a_5a5a_ffff_fff8, 1'b1);
    for (int k = 0; k < 16; k++) send_byte(sb.pat_byte(k), k == 15);
    wait_idle();

    // wildcard second byte, address wraps to zero, later bytes stay silent
    program_block(64'h0000_0000_0000_00ff, 64'h0, 64'h1, 64'h2, 64'hffff_ffff, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h37, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    // pattern start on the final byte must not match
    send_byte(8'h11, 1'b0);
    send_byte(8'hff, 1'b1);
    wait_idle();

    start_bytes = sb.n_bytes;
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_idle_pct  = 21;
          recv_stall_pct = 49;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 21;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (sb.n_bytes < start_bytes + (m + 1) * RANDOM_BYTES / 3) begin
        random_config();
        repeat (6) send_scan_region();
        wait_idle();
      end
    end

    repeat (10) @(posedge clk_i);
    $display("scanned %0d bytes under %0d register settings", sb.n_bytes, settings_used);
    $display("regions with a match: %0d, regions ending without one: %0d",
             sb.n_found, sb.n_missed);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_wildcard_byte_pattern_search passed");
    end else begin
      $display("tb_wildcard_byte_pattern_search failed");
    end
    $finish;
  end

endmodule
